// ===== hdl/svf_pkg.sv =====
package svf_pkg;

  localparam int CHANNELS_DEF = 2;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_FRAC_BITS_DEF = 24;
  localparam int COEF_BITS = 32;
  localparam int STATE_BITS = 40;
  // Each exact product term is 32 bits times at most 42 bits.
  localparam int OPND_BITS = 42;
  localparam int PROD_BITS = COEF_BITS + OPND_BITS;
  localparam int REG_INDEX_BITS = 3;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_BYPASS = 3'd0,
    REG_A1     = 3'd1,
    REG_A2     = 3'd2,
    REG_A3     = 3'd3,
    REG_M0     = 3'd4,
    REG_M1     = 3'd5,
    REG_M2     = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_NEXT,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/stereo_state_variable_filter.sv =====
// Stereo trapezoidal state-variable filter with a programmable output mix.
// Input frames arrive on the s_axis group: tdata holds left_in in the low
// SAMPLE_BITS and right_in above it. Results leave on m_axis: tdata holds
// left_out then right_out, and tuser carries the clipped flag.
// Coefficients and mix weights are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Index 0 is bypass, 1..6 are a1, a2, a3, m0, m1, m2.
// Each channel runs seven product terms through one bit-serial multiplier:
// per term, a load, then the coefficient shifts out one bit a cycle, then
// an accumulate and a step to the next term. In filter mode m_axis_tvalid
// rises once all terms of every channel are done; in bypass the input frame
// is copied to the output register and m_axis_tvalid rises without them.
// One frame is processed at a time; s_axis_tready is low from acceptance
// until the result has been transferred out. The result waits in the output
// register while m_axis_tready is low, and a stall holds off the next frame.
// Reset (rst, synchronous) clears both integrators of every channel, sets
// bypass to 1, a1 and m0 to 1.0 and the other coefficients to 0.
module stereo_state_variable_filter
  import svf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // channel 0 sample, channel 1 sample, ... from bit 0 up
  input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // channel 0 result, channel 1 result, ... from bit 0 up
  output logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // bit 0: clipped
  output logic m_axis_tuser,
  input  logic cfg_we,
  input  logic [REG_INDEX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0] cfg_data
);

  localparam int DATA_W = ((CHANNELS*SAMPLE_BITS+7)/8)*8;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(COEF_BITS+1);
  localparam int ACC_BITS = PROD_BITS - COEF_FRAC_BITS + 2;
  localparam logic signed [ACC_BITS-1:0] Y_MAX =
    (ACC_BITS'(1) <<< (SAMPLE_BITS-1)) - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] Y_MIN = -Y_MAX - ACC_BITS'(1);

  logic bypass;
  logic signed [COEF_BITS-1:0] a1, a2, a3, m0, m1, m2;
  logic signed [STATE_BITS-1:0] ic1 [CHANNELS];
  logic signed [STATE_BITS-1:0] ic2 [CHANNELS];

  state_t state, state_next;
  logic [CH_W-1:0] ch;
  logic [2:0] term;
  logic [CNT_W-1:0] bitcnt;
  logic [CHANNELS*SAMPLE_BITS-1:0] in_buf;
  logic [DATA_W-1:0] out_data;
  logic clip;

  // Bit-serial multiplier: coefficient shifts out LSB first, the operand
  // shifts left, and the product accumulates; the top bit is subtracted.
  logic [COEF_BITS-1:0] mc_sr;
  logic signed [PROD_BITS-1:0] md_sr;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0] acc;
  logic signed [STATE_BITS-1:0] v1, v2;

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [STATE_BITS:0] v3;
  logic signed [COEF_BITS-1:0] t_coef;
  logic signed [OPND_BITS-1:0] t_opnd;
  logic signed [ACC_BITS-1:0] prod_q;

  function automatic logic signed [STATE_BITS-1:0] sat_st(
    input logic signed [ACC_BITS-1:0] v);
    logic signed [ACC_BITS-1:0] hi, lo;
    begin
      hi = ACC_BITS'(signed'({1'b0, {(STATE_BITS-1){1'b1}}}));
      lo = -hi - ACC_BITS'(1);
      if (v > hi) sat_st = hi[STATE_BITS-1:0];
      else if (v < lo) sat_st = lo[STATE_BITS-1:0];
      else sat_st = v[STATE_BITS-1:0];
    end
  endfunction

  assign x = in_buf[ch*SAMPLE_BITS +: SAMPLE_BITS];
  assign v3 = (STATE_BITS+1)'(x) - (STATE_BITS+1)'(ic2[ch]);
  assign prod_q = ACC_BITS'(prod >>> COEF_FRAC_BITS);

  // Term sequence per channel:
  // 0 a1*ic1, 1 a2*v3 -> v1; 2 a2*ic1, 3 a3*v3 (+ic2) -> v2;
  // 4 m0*x, 5 m1*v1, 6 m2*v2 -> y.
  always_comb begin
    case (term)
      3'd0: begin t_coef = a1; t_opnd = OPND_BITS'(ic1[ch]); end
      3'd1: begin t_coef = a2; t_opnd = OPND_BITS'(v3); end
      3'd2: begin t_coef = a2; t_opnd = OPND_BITS'(ic1[ch]); end
      3'd3: begin t_coef = a3; t_opnd = OPND_BITS'(v3); end
      3'd4: begin t_coef = m0; t_opnd = OPND_BITS'(x); end
      3'd5: begin t_coef = m1; t_opnd = OPND_BITS'(v1); end
      default: begin t_coef = m2; t_opnd = OPND_BITS'(v2); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b1;
      a1 <= COEF_BITS'(1) << COEF_FRAC_BITS;
      a2 <= '0;
      a3 <= '0;
      m0 <= COEF_BITS'(1) << COEF_FRAC_BITS;
      m1 <= '0;
      m2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BYPASS: bypass <= cfg_data[0];
        REG_A1: a1 <= cfg_data;
        REG_A2: a2 <= cfg_data;
        REG_A3: a3 <= cfg_data;
        REG_M0: m0 <= cfg_data;
        REG_M1: m1 <= cfg_data;
        REG_M2: m2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_LOAD;
      ST_LOAD: state_next = bypass ? ST_OUT : ST_MUL;
      ST_MUL:  if (bitcnt == CNT_W'(COEF_BITS-1)) state_next = ST_ACC;
      ST_ACC:  state_next = ST_NEXT;
      ST_NEXT: begin
        if (term == 3'd6 && ch == CH_W'(CHANNELS-1)) state_next = ST_OUT;
        else state_next = ST_LOAD;
      end
      ST_OUT:  if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = out_data;
  assign m_axis_tuser = clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ic1[i] <= '0;
        ic2[i] <= '0;
      end
      ch <= '0;
      term <= '0;
      bitcnt <= '0;
      clip <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          in_buf <= s_axis_tdata[CHANNELS*SAMPLE_BITS-1:0];
          out_data <= '0;
          acc <= '0;
          ch <= '0;
          term <= '0;
          clip <= 1'b0;
        end
        ST_LOAD: begin
          if (bypass) out_data <= DATA_W'(in_buf);
          mc_sr <= t_coef;
          md_sr <= PROD_BITS'(t_opnd);
          prod <= '0;
          bitcnt <= '0;
        end
        ST_MUL: begin
          if (bitcnt == CNT_W'(COEF_BITS-1)) begin
            if (mc_sr[0]) prod <= prod - md_sr;
          end else if (mc_sr[0]) begin
            prod <= prod + md_sr;
          end
          mc_sr <= mc_sr >> 1;
          md_sr <= md_sr <<< 1;
          bitcnt <= bitcnt + CNT_W'(1);
        end
        ST_ACC: begin
          case (term)
            3'd1: v1 <= sat_st(acc + prod_q);
            3'd3: v2 <= sat_st(acc + prod_q + ACC_BITS'(ic2[ch]));
            3'd6: begin
              if (acc + prod_q > Y_MAX) begin
                out_data[ch*SAMPLE_BITS +: SAMPLE_BITS] <= SAMPLE_BITS'(Y_MAX);
                clip <= 1'b1;
              end else if (acc + prod_q < Y_MIN) begin
                out_data[ch*SAMPLE_BITS +: SAMPLE_BITS] <= SAMPLE_BITS'(Y_MIN);
                clip <= 1'b1;
              end else begin
                out_data[ch*SAMPLE_BITS +: SAMPLE_BITS] <=
                  SAMPLE_BITS'(acc + prod_q);
              end
            end
            default: ;
          endcase
          if (term == 3'd1 || term == 3'd3 || term == 3'd6) acc <= '0;
          else acc <= acc + prod_q;
        end
        ST_NEXT: begin
          // State updates once v1 and v2 of this channel are known.
          if (term == 3'd3) begin
            ic1[ch] <= sat_st((ACC_BITS'(v1) <<< 1) - ACC_BITS'(ic1[ch]));
            ic2[ch] <= sat_st((ACC_BITS'(v2) <<< 1) - ACC_BITS'(ic2[ch]));
          end
          if (term == 3'd6) begin
            term <= '0;
            if (ch != CH_W'(CHANNELS-1)) ch <= ch + CH_W'(1);
          end else begin
            term <= term + 3'd1;
          end
          prod <= '0;
          bitcnt <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/svf_checker.sv =====
module svf_checker
  import svf_pkg::*;
#(
  parameter int DATA_W = 48
) (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic m_axis_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second frame taken before result");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input open while result pending");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind stereo_state_variable_filter svf_checker #(.DATA_W(DATA_W)) u_svf_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
